// ----- hw/rtl/s1h_pkg.sv -----
// types, constants and helper functions shared by the sha-1 stream hasher
`timescale 1ns / 1ps

package s1h_pkg;

    // block geometry
    localparam int unsigned BLOCK_BYTES = 64;
    localparam int unsigned POS_W       = 6;
    localparam int unsigned WIN_WORDS   = 16;
    localparam int unsigned HASH_WORDS  = 5;
    localparam int unsigned ROUNDS      = 80;
    localparam int unsigned ROUND_W     = 7;
    localparam int unsigned WIDX_W      = 3;

    localparam logic [POS_W-1:0]   POS_BLOCK_LAST = 6'd63;
    localparam logic [POS_W-1:0]   POS_LEN_FIRST  = 6'd56;
    localparam logic [ROUND_W-1:0] ROUND_LAST     = 7'd79;
    localparam logic [WIDX_W-1:0]  WIDX_LAST      = 3'd4;

    localparam logic [7:0] PAD_MARK = 8'h80;

    // initial chaining words
    localparam logic [31:0] H_INIT [HASH_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // round constants, one per group of twenty rounds
    localparam logic [31:0] K_GROUP0 = 32'h5A827999;
    localparam logic [31:0] K_GROUP1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_GROUP2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_GROUP3 = 32'hCA62C1D6;

    typedef enum logic [1:0] {
        GRP_CHOOSE,
        GRP_PARITY_A,
        GRP_MAJORITY,
        GRP_PARITY_B
    } s1h_group_t;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD_MARK,
        ST_PAD_ZERO,
        ST_PAD_LEN,
        ST_ROUND,
        ST_ADD,
        ST_EMIT
    } s1h_state_t;

    // one classified item held in the command queue
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       is_end;
    } s1h_cmd_t;

    // front to queue
    typedef struct packed {
        logic     push;
        s1h_cmd_t cmd;
    } s1h_push_t;

    // queue to front and back
    typedef struct packed {
        logic     full;
        logic     not_empty;
        s1h_cmd_t head;
    } s1h_qstat_t;

    function automatic s1h_group_t round_group(input logic [ROUND_W-1:0] t);
        s1h_group_t g;
        if (t < 7'd20)
        begin
            g = GRP_CHOOSE;
        end
        else if (t < 7'd40)
        begin
            g = GRP_PARITY_A;
        end
        else if (t < 7'd60)
        begin
            g = GRP_MAJORITY;
        end
        else
        begin
            g = GRP_PARITY_B;
        end
        return g;
    endfunction

    function automatic logic [31:0] round_k(input s1h_group_t g);
        logic [31:0] k;
        case (g)
            GRP_CHOOSE:   k = K_GROUP0;
            GRP_PARITY_A: k = K_GROUP1;
            GRP_MAJORITY: k = K_GROUP2;
            GRP_PARITY_B: k = K_GROUP3;
            default:      k = K_GROUP0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] round_f(input s1h_group_t g, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (g)
            GRP_CHOOSE:   f = (b & c) | (~b & d);
            GRP_MAJORITY: f = (b & c) | (b & d) | (c & d);
            GRP_PARITY_A: f = b ^ c ^ d;
            GRP_PARITY_B: f = b ^ c ^ d;
            default:      f = b ^ c ^ d;
        endcase
        return f;
    endfunction

endpackage

// ----- hw/rtl/s1h_stream_if.sv -----
// handshake channels for message bytes and digest words
`timescale 1ns / 1ps

interface s1h_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;

    modport source (output valid, output data_byte, output byte_present,
                    output end_of_message, input ready);
    modport sink   (input valid, input data_byte, input byte_present,
                    input end_of_message, output ready);
endinterface

interface s1h_digest_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    modport source (output valid, output digest_word, output word_index,
                    output last_word, input ready);
    modport sink   (input valid, input digest_word, input word_index,
                    input last_word, output ready);
endinterface

// ----- hw/rtl/s1h_front.sv -----
// front end: takes message beats, drops empty ones, forwards commands
`timescale 1ns / 1ps

module s1h_front
    import s1h_pkg::*;
(
    s1h_msg_if.sink     msg,
    input  s1h_qstat_t  qstat,
    output s1h_push_t   qpush
);

    logic beat;
    logic useful;

    // accept whenever the queue has room
    assign msg.ready = ~qstat.full;
    assign beat      = msg.valid & msg.ready;

    // an item with neither a byte nor an end changes nothing
    assign useful = msg.byte_present | msg.end_of_message;

    always_comb
    begin
        qpush.push         = beat & useful;
        qpush.cmd.data     = msg.data_byte;
        qpush.cmd.has_byte = msg.byte_present;
        qpush.cmd.is_end   = msg.end_of_message;
    end

endmodule

// ----- hw/rtl/s1h_cmd_queue.sv -----
// small command queue between the front and back ends
`timescale 1ns / 1ps

module s1h_cmd_queue
    import s1h_pkg::*;
#(
    parameter int unsigned DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  s1h_push_t  qpush,
    input  logic       pop,
    output s1h_qstat_t qstat
);

    localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
    localparam logic [ADDR_W-1:0] PTR_LAST = ADDR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL = CNT_W'(DEPTH);

    s1h_cmd_t          slot_reg [DEPTH];
    logic [ADDR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [ADDR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push;
    logic              do_pop;

    assign do_push = qpush.push & (count_reg != CNT_FULL);
    assign do_pop  = pop & (count_reg != '0);

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= qpush.cmd;
        end
    end

    always_comb
    begin
        qstat.full      = (count_reg == CNT_FULL);
        qstat.not_empty = (count_reg != '0);
        qstat.head      = slot_reg[rd_ptr_reg];
    end

endmodule

// ----- hw/rtl/s1h_back.sv -----
// back end: block assembly, padding, 80-round compression and digest output
`timescale 1ns / 1ps

module s1h_back
    import s1h_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  s1h_qstat_t   qstat,
    output logic         pop,
    s1h_digest_if.source digest
);

    s1h_state_t          state_reg, state_next;
    s1h_state_t          ret_reg, ret_next;
    logic [POS_W-1:0]    pos_reg;
    logic [63:0]         bit_len_reg;
    logic [ROUND_W-1:0]  round_reg;
    logic [WIDX_W-1:0]   emit_idx_reg;
    logic [31:0]         h_reg [HASH_WORDS];
    logic [31:0]         work_reg [HASH_WORDS];
    logic [31:0]         win_reg [WIN_WORDS];
    logic [23:0]         acc_reg;
    logic                out_valid_reg;
    logic [31:0]         out_word_reg;
    logic [WIDX_W-1:0]   out_idx_reg;
    logic                out_last_reg;

    logic                insert_en;
    logic [7:0]          insert_byte;
    logic                block_done;
    logic                len_inc;
    logic                round_en;
    logic                add_en;
    logic                out_load;
    logic                restart;
    logic [63:0]         len_shift;
    s1h_group_t          grp;
    logic [31:0]         f_val;
    logic [31:0]         tmp_val;
    logic [31:0]         sched_word;

    // length bytes go out most significant first
    assign len_shift  = bit_len_reg << {pos_reg[2:0], 3'b000};
    assign block_done = (pos_reg == POS_BLOCK_LAST);

    // next state
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (qstat.not_empty)
                begin
                    if (qstat.head.has_byte && block_done)
                    begin
                        state_next = ST_ROUND;
                        ret_next   = qstat.head.is_end ? ST_PAD_MARK : ST_IDLE;
                    end
                    else if (qstat.head.is_end)
                    begin
                        state_next = ST_PAD_MARK;
                    end
                end
            end
            ST_PAD_MARK:
            begin
                if (block_done)
                begin
                    state_next = ST_ROUND;
                    ret_next   = ST_PAD_ZERO;
                end
                else
                begin
                    state_next = ST_PAD_ZERO;
                end
            end
            ST_PAD_ZERO:
            begin
                if (pos_reg == POS_LEN_FIRST)
                begin
                    state_next = ST_PAD_LEN;
                end
                else if (block_done)
                begin
                    state_next = ST_ROUND;
                    ret_next   = ST_PAD_ZERO;
                end
            end
            ST_PAD_LEN:
            begin
                if (block_done)
                begin
                    state_next = ST_ROUND;
                    ret_next   = ST_EMIT;
                end
            end
            ST_ROUND:
            begin
                if (round_reg == ROUND_LAST)
                begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD:
            begin
                state_next = ret_reg;
            end
            ST_EMIT:
            begin
                if (out_load && (emit_idx_reg == WIDX_LAST))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control outputs of the sequencer
    always_comb
    begin
        pop         = 1'b0;
        insert_en   = 1'b0;
        insert_byte = 8'h00;
        len_inc     = 1'b0;
        round_en    = 1'b0;
        add_en      = 1'b0;
        out_load    = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                pop         = qstat.not_empty;
                insert_en   = qstat.not_empty & qstat.head.has_byte;
                insert_byte = qstat.head.data;
                len_inc     = insert_en;
            end
            ST_PAD_MARK:
            begin
                insert_en   = 1'b1;
                insert_byte = PAD_MARK;
            end
            ST_PAD_ZERO:
            begin
                insert_en   = (pos_reg != POS_LEN_FIRST);
                insert_byte = 8'h00;
            end
            ST_PAD_LEN:
            begin
                insert_en   = 1'b1;
                insert_byte = len_shift[63:56];
            end
            ST_ROUND:
            begin
                round_en = 1'b1;
            end
            ST_ADD:
            begin
                add_en = 1'b1;
            end
            ST_EMIT:
            begin
                out_load = ~out_valid_reg | digest.ready;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    assign restart = out_load & (emit_idx_reg == WIDX_LAST);

    // round function
    assign grp     = round_group(round_reg);
    assign f_val   = round_f(grp, work_reg[1], work_reg[2], work_reg[3]);
    assign tmp_val = {work_reg[0][26:0], work_reg[0][31:27]} + f_val + work_reg[4]
                     + round_k(grp) + win_reg[0];

    // next schedule word from the sliding window
    always_comb
    begin
        sched_word = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
        sched_word = {sched_word[30:0], sched_word[31]};
    end

    // sequencer, counters and chaining words
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            ret_reg      <= ST_IDLE;
            pos_reg      <= '0;
            bit_len_reg  <= '0;
            round_reg    <= '0;
            emit_idx_reg <= '0;
            for (int i = 0; i < HASH_WORDS; i++)
            begin
                h_reg[i] <= H_INIT[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            if (insert_en)
            begin
                pos_reg <= pos_reg + 1'b1;
            end
            if (len_inc)
            begin
                bit_len_reg <= bit_len_reg + 64'd8;
            end
            if (round_en)
            begin
                round_reg <= (round_reg == ROUND_LAST) ? '0 : round_reg + 1'b1;
            end
            if (add_en)
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                begin
                    h_reg[i] <= h_reg[i] + work_reg[i];
                end
            end
            if (out_load)
            begin
                emit_idx_reg <= restart ? '0 : emit_idx_reg + 1'b1;
            end
            // back to initial values once the last digest word is loaded
            if (restart)
            begin
                bit_len_reg <= '0;
                pos_reg     <= '0;
                for (int i = 0; i < HASH_WORDS; i++)
                begin
                    h_reg[i] <= H_INIT[i];
                end
            end
        end
    end

    // byte gathering, message schedule window and working variables
    always_ff @(posedge clk)
    begin
        if (insert_en)
        begin
            if (pos_reg[1:0] == 2'b11)
            begin
                for (int i = 0; i < WIN_WORDS - 1; i++)
                begin
                    win_reg[i] <= win_reg[i + 1];
                end
                win_reg[WIN_WORDS-1] <= {acc_reg, insert_byte};
            end
            else
            begin
                acc_reg <= {acc_reg[15:0], insert_byte};
            end
            if (block_done)
            begin
                for (int i = 0; i < HASH_WORDS; i++)
                begin
                    work_reg[i] <= h_reg[i];
                end
            end
        end
        if (round_en)
        begin
            for (int i = 0; i < WIN_WORDS - 1; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[WIN_WORDS-1] <= sched_word;
            work_reg[0] <= tmp_val;
            work_reg[1] <= work_reg[0];
            work_reg[2] <= {work_reg[1][1:0], work_reg[1][31:2]};
            work_reg[3] <= work_reg[2];
            work_reg[4] <= work_reg[3];
        end
    end

    // output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (digest.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_word_reg <= h_reg[emit_idx_reg];
            out_idx_reg  <= emit_idx_reg;
            out_last_reg <= (emit_idx_reg == WIDX_LAST);
        end
    end

    assign digest.valid       = out_valid_reg;
    assign digest.digest_word = out_word_reg;
    assign digest.word_index  = out_idx_reg;
    assign digest.last_word   = out_last_reg;

endmodule

// ----- hw/rtl/sha1_stream_hasher_unit.sv -----
// SHA-1 stream hasher: one message byte per beat in, five digest words out per message.
// The front end takes a beat in every cycle while the command queue has room and drops
// beats that carry neither a byte nor an end. The back end drains one byte per cycle
// into the block buffer while no compression runs; each full 64-byte block then runs 80
// rounds on one shared round unit and is then folded into the chaining words. At an end
// of message the padding bytes are written one per cycle while no compression runs (up to
// 72), with one or two compressions, and the five digest words leave through an output
// register, one per cycle while the sink is ready. No clearing pass is needed after reset.
`timescale 1ns / 1ps

module sha1_stream_hasher_unit
    import s1h_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = 4
)
(
    input  logic         clk,
    input  logic         rst_n,
    s1h_msg_if.sink      msg,
    s1h_digest_if.source digest
);

    s1h_push_t  qpush;
    s1h_qstat_t qstat;
    logic       pop;

    // classify incoming beats
    s1h_front u_front (
        .msg   (msg),
        .qstat (qstat),
        .qpush (qpush)
    );

    // decouple front and back
    s1h_cmd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .qpush (qpush),
        .pop   (pop),
        .qstat (qstat)
    );

    // hashing engine
    s1h_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .qstat  (qstat),
        .pop    (pop),
        .digest (digest)
    );

endmodule

// ----- hw/rtl/s1h_checker.sv -----
// port-level checks for the sha-1 stream hasher, bound to the top level
`timescale 1ns / 1ps

module s1h_checker
    import s1h_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        msg_valid,
    input logic        msg_ready,
    input logic        msg_end,
    input logic        dig_valid,
    input logic        dig_ready,
    input logic [31:0] dig_word,
    input logic [2:0]  dig_index,
    input logic        dig_last
);

    logic [WIDX_W-1:0] exp_idx_reg;
    logic [3:0]        pending_reg;
    logic              end_beat;
    logic              last_beat;

    assign end_beat  = msg_valid & msg_ready & msg_end;
    assign last_beat = dig_valid & dig_ready & dig_last;

    // expected word position and open messages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_idx_reg <= '0;
            pending_reg <= '0;
        end
        else
        begin
            if (dig_valid && dig_ready)
            begin
                exp_idx_reg <= dig_last ? '0 : exp_idx_reg + 1'b1;
            end
            case ({end_beat, last_beat})
                2'b10:   pending_reg <= pending_reg + 1'b1;
                2'b01:   pending_reg <= pending_reg - 1'b1;
                default: pending_reg <= pending_reg;
            endcase
        end
    end

    // a stalled digest beat holds its payload
    a_dig_hold: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid && !dig_ready |=> dig_valid && $stable(dig_word) && $stable(dig_index))
        else $error("digest beat changed while stalled");

    // last flag marks exactly the fifth word
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid |-> (dig_last == (dig_index == WIDX_LAST)))
        else $error("last_word does not match word_index");

    // words of a digest come in order
    a_idx_order: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid |-> (dig_index == exp_idx_reg))
        else $error("digest word out of order");

    // no digest without an ended message
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        dig_valid |-> (pending_reg != '0))
        else $error("digest word without an ended message");

endmodule

bind sha1_stream_hasher_unit s1h_checker u_s1h_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .msg_valid (msg.valid),
    .msg_ready (msg.ready),
    .msg_end   (msg.end_of_message),
    .dig_valid (digest.valid),
    .dig_ready (digest.ready),
    .dig_word  (digest.digest_word),
    .dig_index (digest.word_index),
    .dig_last  (digest.last_word)
);

// ----- test/sha1_stream_hasher_unit_tb.sv -----
// self-checking testbench for the sha-1 stream hasher: byte beats in, digest words checked
`timescale 1ns / 1ps

module sha1_stream_hasher_unit_tb;

    import s1h_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 400;
    localparam int unsigned RANDOM_ITEMS = 24;
    localparam int unsigned HOLD_CYCLES  = 400;

    localparam logic [31:0] IV0 = 32'h67452301;
    localparam logic [31:0] IV1 = 32'hEFCDAB89;
    localparam logic [31:0] IV2 = 32'h98BADCFE;
    localparam logic [31:0] IV3 = 32'h10325476;
    localparam logic [31:0] IV4 = 32'hC3D2E1F0;

    localparam logic [31:0] RK0 = 32'h5A827999;
    localparam logic [31:0] RK1 = 32'h6ED9EBA1;
    localparam logic [31:0] RK2 = 32'h8F1BBCDC;
    localparam logic [31:0] RK3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_FIRST_BYTE = 8'h80;
    localparam logic [5:0] LEN_FIELD_POS  = 6'd56;
    localparam logic [5:0] LAST_BYTE_POS  = 6'd63;
    localparam logic [2:0] LAST_WORD_IDX  = 3'd4;

    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  index;
        logic        last;
    } digest_beat_t;

    logic clk;
    logic rst_n;

    s1h_msg_if    msg_ch ();
    s1h_digest_if digest_ch ();

    sha1_stream_hasher_unit i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .digest (digest_ch)
    );

    // predictor state
    logic [31:0]  chain [5];
    logic [7:0]   block_buf [64];
    logic [63:0]  msg_bits;
    digest_beat_t digest_words_due [$];

    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned hold_left;
    bit          idle_on;

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // run limit
    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
        $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
        mismatch_count++;
    endtask

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60)
        begin
            return 0;
        end
        else if (r < 92)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    // chaining value and counts back to their initial values
    function automatic void reset_hash();
        chain[0] = IV0;
        chain[1] = IV1;
        chain[2] = IV2;
        chain[3] = IV3;
        chain[4] = IV4;
        msg_bits = '0;
        for (int i = 0; i < 64; i++)
        begin
            block_buf[i] = 8'h00;
        end
    endfunction

    // 80-round compression of the gathered block into the chaining words
    function automatic void compress_block();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, sum, x;
        for (int r = 0; r < 16; r++)
        begin
            w[r] = {block_buf[4*r], block_buf[4*r+1], block_buf[4*r+2], block_buf[4*r+3]};
        end
        for (int r = 16; r < 80; r++)
        begin
            x    = w[r-3] ^ w[r-8] ^ w[r-14] ^ w[r-16];
            w[r] = {x[30:0], x[31]};
        end
        a = chain[0];
        b = chain[1];
        c = chain[2];
        d = chain[3];
        e = chain[4];
        for (int r = 0; r < 80; r++)
        begin
            if (r < 20)
            begin
                f = (b & c) | (~b & d);
                k = RK0;
            end
            else if (r < 40)
            begin
                f = b ^ c ^ d;
                k = RK1;
            end
            else if (r < 60)
            begin
                f = (b & c) | (b & d) | (c & d);
                k = RK2;
            end
            else
            begin
                f = b ^ c ^ d;
                k = RK3;
            end
            sum = {a[26:0], a[31:27]} + f + e + k + w[r];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = sum;
        end
        chain[0] += a;
        chain[1] += b;
        chain[2] += c;
        chain[3] += d;
        chain[4] += e;
    endfunction

    // absorb one accepted beat; at an end of message pad and queue the five digest words
    function automatic void sha1_absorb(input logic [7:0] data, input logic present,
                                        input logic eom);
        logic [5:0]   pos;
        digest_beat_t beat;
        pos = msg_bits[8:3];
        if (present)
        begin
            block_buf[pos] = data;
            msg_bits += 64'd8;
            if (pos == LAST_BYTE_POS)
            begin
                compress_block();
            end
            pos = msg_bits[8:3];
        end
        if (eom)
        begin
            block_buf[pos] = PAD_FIRST_BYTE;
            for (int i = int'(pos) + 1; i < 64; i++)
            begin
                block_buf[i] = 8'h00;
            end
            // no room for the length field: spill into a second block
            if (pos >= LEN_FIELD_POS)
            begin
                compress_block();
                for (int i = 0; i < 64; i++)
                begin
                    block_buf[i] = 8'h00;
                end
            end
            for (int i = 0; i < 8; i++)
            begin
                block_buf[56 + i] = msg_bits[63 - 8*i -: 8];
            end
            compress_block();
            for (int i = 0; i < 5; i++)
            begin
                beat.word  = chain[i];
                beat.index = 3'(i);
                beat.last  = (3'(i) == LAST_WORD_IDX);
                digest_words_due.push_back(beat);
            end
            reset_hash();
        end
    endfunction

    // offer one beat, with an optional gap first, and wait for it to be taken
    task automatic send_item(input logic [7:0] data, input logic present, input logic eom);
        int unsigned gap;
        gap = idle_on ? pick_gap() : 0;
        if (gap > 0)
        begin
            msg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_ch.valid          <= 1'b1;
        msg_ch.data_byte      <= data;
        msg_ch.byte_present   <= present;
        msg_ch.end_of_message <= eom;
        do
        begin
            @(posedge clk);
        end
        while (!msg_ch.ready);
        sha1_absorb(data, present, eom);
    endtask

    // a whole message of random bytes; the end rides on the last byte or on a beat of its own
    task automatic send_message(input int unsigned len, input bit sep_end, input bit noise);
        for (int unsigned i = 0; i < len; i++)
        begin
            if (noise && $urandom_range(0, 9) == 0)
            begin
                send_item(8'($urandom), 1'b0, 1'b0);
            end
            send_item(8'($urandom), 1'b1, (i == len - 1) && !sep_end);
        end
        if (sep_end || len == 0)
        begin
            send_item(8'($urandom), 1'b0, 1'b1);
        end
    endtask

    // stop offering beats and wait until every due digest word has come out
    task automatic wait_for_digests();
        msg_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (digest_words_due.size() != 0);
    endtask

    // digest sink: check each beat, then pick ready for the next cycle
    initial
    begin
        int unsigned  stall_left;
        digest_beat_t want;
        stall_left = 0;
        digest_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && digest_ch.valid && digest_ch.ready)
            begin
                if (digest_words_due.size() == 0)
                begin
                    report("digest word with none due", digest_ch.digest_word, 32'h0);
                end
                else
                begin
                    want = digest_words_due.pop_front();
                    if (digest_ch.digest_word !== want.word)
                    begin
                        report("digest_word", digest_ch.digest_word, want.word);
                    end
                    if (digest_ch.word_index !== want.index)
                    begin
                        report("word_index", 32'(digest_ch.word_index), 32'(want.index));
                    end
                    if (digest_ch.last_word !== want.last)
                    begin
                        report("last_word", 32'(digest_ch.last_word), 32'(want.last));
                    end
                end
            end
            if (!rst_n)
            begin
                digest_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                digest_ch.ready <= 1'b0;
                hold_left--;
            end
            else if (stall_left > 0)
            begin
                digest_ch.ready <= 1'b0;
                stall_left--;
            end
            else if (idle_on && $urandom_range(0, 3) == 0)
            begin
                stall_left = pick_gap();
                if (stall_left > 0)
                begin
                    digest_ch.ready <= 1'b0;
                    stall_left--;
                end
                else
                begin
                    digest_ch.ready <= 1'b1;
                end
            end
            else
            begin
                digest_ch.ready <= 1'b1;
            end
        end
    end

    // empty message, bytes at both extremes, ends with and without a byte, idle beats
    task automatic test_directed();
        idle_on = 1'b1;
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h5A, 1'b0, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'hFF, 1'b0, 1'b0);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'hA5, 1'b1, 1'b0);
        send_item(8'h5A, 1'b1, 1'b1);
    endtask

    // a length whose padding spills into a second block
    task automatic test_pad_boundaries();
        idle_on = 1'b0;
        send_message(56, 1'b1, 1'b0);
    endtask

    // random messages, mostly short, with idle beats mixed in
    task automatic test_random_messages();
        int unsigned sent;
        int unsigned len;
        bit          sep_end;
        idle_on = 1'b1;
        sent    = 0;
        while (sent < RANDOM_ITEMS)
        begin
            len     = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 20)
                                                 : $urandom_range(50, 70);
            sep_end = ($urandom_range(0, 2) == 0) || (len == 0);
            send_message(len, sep_end, 1'b1);
            sent += len + int'(sep_end);
        end
    endtask

    // digest sink holds off for a long stretch while bytes keep coming
    task automatic test_backpressure();
        wait_for_digests();
        idle_on   = 1'b0;
        hold_left = HOLD_CYCLES;
        for (int i = 0; i < 4; i++)
        begin
            send_message($urandom_range(2, 5), 1'b0, 1'b0);
        end
        idle_on = 1'b1;
    endtask

    initial
    begin
        mismatch_count = 0;
        hold_left      = 0;
        idle_on        = 1'b0;
        reset_hash();
        rst_n                 <= 1'b0;
        msg_ch.valid          <= 1'b0;
        msg_ch.data_byte      <= 8'h00;
        msg_ch.byte_present   <= 1'b0;
        msg_ch.end_of_message <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_pad_boundaries();
        test_random_messages();
        test_backpressure();
        test_random_messages();

        // drain, then watch for stray words
        wait_for_digests();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (digest_words_due.size() != 0)
        begin
            report("digest words never arrived", 32'(digest_words_due.size()), 32'h0);
        end

        if (mismatch_count == 0)
        begin
            $display("SCOREBOARD CLEAN");
        end
        else
        begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ----- sha1_stream_hasher_unit.f -----
hw/rtl/s1h_pkg.sv
hw/rtl/s1h_stream_if.sv
hw/rtl/s1h_front.sv
hw/rtl/s1h_cmd_queue.sv
hw/rtl/s1h_back.sv
hw/rtl/sha1_stream_hasher_unit.sv
hw/rtl/s1h_checker.sv
test/sha1_stream_hasher_unit_tb.sv
